>>> design/tlwm_pkg.sv
// ----------------------------------------------------------------------------
// tlwm_pkg
// Shared types and constants for the text line wrap and measure block.
// ----------------------------------------------------------------------------
package tlwm_pkg;

	localparam int unsigned LEN_W    = 20;  // line width, 1/16 pixel
	localparam int unsigned HGT_W    = 16;  // glyph and line height
	localparam int unsigned SUM_W    = 24;  // summed string height
	localparam int unsigned IDX_W    = 16;  // character index
	localparam int unsigned GLYPH_W  = 16;  // glyph advance
	localparam int unsigned CODE_W   = 16;  // UTF-16 code unit
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 20;

	localparam logic [IDX_W-1:0]  MAX_CHARS = 16'hFFFF;
	localparam logic [CODE_W-1:0] CH_CR     = 16'd13;
	localparam logic [CODE_W-1:0] CH_LF     = 16'd10;
	localparam logic [HGT_W-1:0]  MIN_HEIGHT_RST = 16'd256;

	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// Input item kinds
	localparam logic CMD_CHAR = 1'b0;
	localparam logic CMD_END  = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_SPACING = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_HEIGHT   = 2'd2;

	localparam int unsigned IN_DATA_W  = 56;
	localparam int unsigned OUT_DATA_W = 112;

	typedef struct packed {
		logic [LEN_W-1:0] wrap_width;
		logic [HGT_W-1:0] line_spacing;
		logic [HGT_W-1:0] min_line_height;
	} tlwm_cfg_t;

	typedef struct packed {
		logic               cmd;
		logic [CODE_W-1:0]  char_code;
		logic               glyph_present;
		logic [GLYPH_W-1:0] glyph_width;
		logic [HGT_W-1:0]   glyph_height;
	} tlwm_item_t;

	typedef struct packed {
		logic [LEN_W-1:0] cur_w;
		logic [HGT_W-1:0] cur_h;
		logic [LEN_W-1:0] widest;
		logic [SUM_W-1:0] hsum;
		logic             after_cr;
		logic [IDX_W-1:0] first_idx;
		logic [IDX_W-1:0] char_idx;
	} tlwm_state_t;

	typedef struct packed {
		logic [SUM_W-1:0] total_height;
		logic [LEN_W-1:0] total_width;
		logic [HGT_W-1:0] line_height;
		logic [LEN_W-1:0] line_width;
		logic [IDX_W-1:0] line_stop;
		logic [IDX_W-1:0] line_begin;
	} tlwm_rec_t;

endpackage

>>> design/tlwm_step.sv
// ----------------------------------------------------------------------------
// tlwm_step
// Next-state and line record logic for one registered input item.
// ----------------------------------------------------------------------------
module tlwm_step (
	input  tlwm_pkg::tlwm_cfg_t   cfg,
	input  tlwm_pkg::tlwm_state_t st,
	input  tlwm_pkg::tlwm_item_t  item,
	output tlwm_pkg::tlwm_state_t nxt,
	output logic                  rec_valid,
	output logic                  rec_last,
	output tlwm_pkg::tlwm_rec_t   rec
);

	logic [tlwm_pkg::IDX_W-1:0] next_idx;
	logic [tlwm_pkg::SUM_W+1:0] end_sum_raw;
	logic [tlwm_pkg::SUM_W-1:0] end_sum;
	logic [tlwm_pkg::SUM_W:0]   last_sum_raw;
	logic [tlwm_pkg::SUM_W-1:0] last_sum;
	logic [tlwm_pkg::LEN_W-1:0] end_widest;
	logic [tlwm_pkg::LEN_W:0]   new_w;
	logic                       wrap_break;
	tlwm_pkg::tlwm_rec_t        line_rec;

	always_comb begin
		next_idx = (st.char_idx < tlwm_pkg::MAX_CHARS) ? st.char_idx + 1'b1
			: tlwm_pkg::MAX_CHARS;
		end_sum_raw = {2'b00, st.hsum} + {10'd0, st.cur_h} + {10'd0, cfg.line_spacing};
		end_sum = (end_sum_raw > {2'b00, tlwm_pkg::SUM_MAX}) ? tlwm_pkg::SUM_MAX
			: end_sum_raw[tlwm_pkg::SUM_W-1:0];
		last_sum_raw = {1'b0, st.hsum} + {9'd0, st.cur_h};
		last_sum = last_sum_raw[tlwm_pkg::SUM_W] ? tlwm_pkg::SUM_MAX
			: last_sum_raw[tlwm_pkg::SUM_W-1:0];
		end_widest = (st.cur_w > st.widest) ? st.cur_w : st.widest;
		new_w = {1'b0, st.cur_w} + {5'd0, item.glyph_width};
		wrap_break = (cfg.wrap_width != '0) && (new_w > {1'b0, cfg.wrap_width})
			&& (st.cur_w != '0);

		// record of a line ended by a break
		line_rec.line_begin   = st.first_idx;
		line_rec.line_stop    = st.char_idx;
		line_rec.line_width   = st.cur_w;
		line_rec.line_height  = st.cur_h;
		line_rec.total_width  = end_widest;
		line_rec.total_height = end_sum;

		nxt       = st;
		rec_valid = 1'b0;
		rec_last  = 1'b0;
		rec       = line_rec;

		if (item.cmd == tlwm_pkg::CMD_END) begin
			rec_valid         = 1'b1;
			rec_last          = 1'b1;
			rec.total_height  = last_sum;
			nxt.cur_w         = '0;
			nxt.cur_h         = cfg.min_line_height;
			nxt.widest        = '0;
			nxt.hsum          = '0;
			nxt.after_cr      = 1'b0;
			nxt.first_idx     = '0;
			nxt.char_idx      = '0;
		end else begin
			nxt.char_idx = next_idx;
			nxt.after_cr = 1'b0;
			if (item.char_code == tlwm_pkg::CH_CR ||
			    (item.char_code == tlwm_pkg::CH_LF && !st.after_cr)) begin
				rec_valid     = 1'b1;
				nxt.hsum      = end_sum;
				nxt.widest    = end_widest;
				nxt.cur_h     = cfg.min_line_height;
				nxt.cur_w     = '0;
				nxt.first_idx = next_idx;
				nxt.after_cr  = (item.char_code == tlwm_pkg::CH_CR);
			end else if (item.char_code == tlwm_pkg::CH_LF) begin
				// LF right after CR: one break, already counted
				nxt.first_idx = next_idx;
			end else if (item.glyph_present) begin
				if (wrap_break) begin
					rec_valid     = 1'b1;
					nxt.hsum      = end_sum;
					nxt.widest    = end_widest;
					nxt.cur_h     = (item.glyph_height > cfg.min_line_height)
						? item.glyph_height : cfg.min_line_height;
					nxt.cur_w     = {4'd0, item.glyph_width};
					nxt.first_idx = st.char_idx;
				end else begin
					nxt.cur_w = new_w[tlwm_pkg::LEN_W] ? tlwm_pkg::LEN_MAX
						: new_w[tlwm_pkg::LEN_W-1:0];
					nxt.cur_h = (item.glyph_height > st.cur_h) ? item.glyph_height
						: st.cur_h;
				end
			end
		end
	end

endmodule

>>> design/text_line_wrap_measure_top.sv
// ----------------------------------------------------------------------------
// text_line_wrap_measure_top
// Greedy line wrapping and measuring of a character stream.
// ----------------------------------------------------------------------------
// Feed one character word per cycle; the block takes a new word every cycle
// for as long as the result side keeps up; the word that ends a line goes to
// the input register, then its record to the result register. The running
// line state (width, height, indices, totals) is updated once per word by
// add, compare and max logic, which is what sets the one-word-per-cycle
// rate. A CR, an LF not right after a CR, a wrap break or an end-of-string
// word each give one record; other words give none. An end-of-string word
// (tuser = 1) gives the last record with tlast high and returns the string
// state to start values, line height min_line_height. Write the configuration
// registers only while the block is idle; a write of min_line_height also
// reloads the current line height while no character of the string has come.
// ----------------------------------------------------------------------------
module text_line_wrap_measure_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_wr_en,
	input  logic [tlwm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tlwm_pkg::CFG_DATA_W-1:0]     cfg_data,
	// character stream in
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// char_code[15:0], glyph_present[16], glyph_width[32:17],
	// glyph_height[48:33], zero fill [55:49]
	input  logic [tlwm_pkg::IN_DATA_W-1:0]      s_tdata,
	// cmd[0]
	input  logic                                s_tuser,
	// line records out
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// line_begin[15:0], line_stop[31:16], line_width_out[51:32],
	// line_height_out[67:52], total_width[87:68], total_height[111:88]
	output logic [tlwm_pkg::OUT_DATA_W-1:0]     m_tdata,
	// last
	output logic                                m_tlast
);

	tlwm_pkg::tlwm_cfg_t   cfg_q;
	tlwm_pkg::tlwm_state_t st_q;
	tlwm_pkg::tlwm_state_t st_nxt;
	tlwm_pkg::tlwm_item_t  item_in;
	tlwm_pkg::tlwm_item_t  item_s1;
	logic                  valid_s1;
	logic                  out_valid_q;
	logic                  out_last_q;
	tlwm_pkg::tlwm_rec_t   out_rec_q;
	logic                  rec_valid;
	logic                  rec_last;
	tlwm_pkg::tlwm_rec_t   rec;
	logic                  advance;
	logic                  take_in;

	// unpack the input word
	assign item_in.cmd           = s_tuser;
	assign item_in.char_code     = s_tdata[15:0];
	assign item_in.glyph_present = s_tdata[16];
	assign item_in.glyph_width   = s_tdata[32:17];
	assign item_in.glyph_height  = s_tdata[48:33];

	// advance whenever the result register is free or being drained
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign take_in  = s_tvalid && s_tready;

	tlwm_step u_step (
		.cfg       (cfg_q),
		.st        (st_q),
		.item      (item_s1),
		.nxt       (st_nxt),
		.rec_valid (rec_valid),
		.rec_last  (rec_last),
		.rec       (rec)
	);

	// configuration registers and running string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wrap_width      <= '0;
			cfg_q.line_spacing    <= '0;
			cfg_q.min_line_height <= tlwm_pkg::MIN_HEIGHT_RST;
			st_q.cur_w            <= '0;
			st_q.cur_h            <= tlwm_pkg::MIN_HEIGHT_RST;
			st_q.widest           <= '0;
			st_q.hsum             <= '0;
			st_q.after_cr         <= 1'b0;
			st_q.first_idx        <= '0;
			st_q.char_idx         <= '0;
		end else begin
			// state steps when a registered word is processed
			if (valid_s1 && advance) begin
				st_q <= st_nxt;
			end else if (cfg_wr_en && (cfg_index == tlwm_pkg::REG_MIN_HEIGHT)
					&& (st_q.char_idx == '0)) begin
				// reload only before the string's first character
				st_q.cur_h <= cfg_data[tlwm_pkg::HGT_W-1:0];
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					tlwm_pkg::REG_WRAP_WIDTH: begin
						cfg_q.wrap_width <= cfg_data;
					end
					tlwm_pkg::REG_LINE_SPACING: begin
						cfg_q.line_spacing <= cfg_data[tlwm_pkg::HGT_W-1:0];
					end
					tlwm_pkg::REG_MIN_HEIGHT: begin
						cfg_q.min_line_height <= cfg_data[tlwm_pkg::HGT_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= take_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= item_in;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && rec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && rec_valid) begin
			out_rec_q  <= rec;
			out_last_q <= rec_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {out_rec_q.total_height, out_rec_q.total_width,
		out_rec_q.line_height, out_rec_q.line_width,
		out_rec_q.line_stop, out_rec_q.line_begin};

endmodule

>>> design/tlwm_checker.sv
// ----------------------------------------------------------------------------
// tlwm_checker
// Port-level checks for the text line wrap and measure block.
// ----------------------------------------------------------------------------
module tlwm_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [tlwm_pkg::OUT_DATA_W-1:0]     m_tdata,
	input logic                                m_tlast
);

	// a stalled record holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("line record changed while stalled");

	// a line never begins after it stops
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:0] <= m_tdata[31:16])
		else $error("line_begin past line_stop");

	// the widest line covers this line
	a_width: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[87:68] >= m_tdata[51:32])
		else $error("total_width below line width");

	// the height sum covers this line
	a_height: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[111:88] >= {8'd0, m_tdata[67:52]})
		else $error("total_height below line height");

endmodule

bind text_line_wrap_measure_top tlwm_checker u_tlwm_checker (.*);

>>> verif/tlwm_checker.sv
// ----------------------------------------------------------------------------
// tlwm_scoreboard
// Watches the word and record streams of the line wrap block, predicts every
// line record from its own copy of the string state and compares.
// ----------------------------------------------------------------------------
module tlwm_scoreboard import tlwm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	// char_code[15:0], glyph_present[16], glyph_width[32:17], glyph_height[48:33]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// cmd[0]
	input  logic                  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// line_begin, line_stop, line_width, line_height, total_width, total_height
	input  logic [OUT_DATA_W-1:0] m_tdata,
	// last
	input  logic                  m_tlast,
	output int                    error_count,
	output int                    pending,
	output int                    records_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic      last;
		tlwm_rec_t rec;
	} line_rec_t;

	line_rec_t line_queue[$];

	// register copies
	logic [LEN_W-1:0] wrap_w;
	logic [HGT_W-1:0] spacing;
	logic [HGT_W-1:0] min_h;

	// string state
	logic [LEN_W-1:0] cur_w;
	logic [HGT_W-1:0] cur_h;
	logic [LEN_W-1:0] widest;
	logic [SUM_W-1:0] hsum;
	logic             after_cr;
	logic [IDX_W-1:0] first_idx;
	logic [IDX_W-1:0] char_idx;

	line_rec_t got;
	line_rec_t exp_rec;

	function automatic logic [IDX_W-1:0] step_index(input logic [IDX_W-1:0] i);
		return (i < MAX_CHARS) ? i + 1'b1 : MAX_CHARS;
	endfunction

	function automatic logic [HGT_W-1:0] taller(input logic [HGT_W-1:0] a,
			input logic [HGT_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	task automatic clear_string();
		cur_w     = '0;
		cur_h     = min_h;
		widest    = '0;
		hsum      = '0;
		after_cr  = 1'b0;
		first_idx = '0;
		char_idx  = '0;
	endtask

	// close the current line at stop and queue its record
	task automatic close_line(input logic [IDX_W-1:0] stop);
		logic [SUM_W+1:0] sum;
		line_rec_t r;
		sum = {2'b00, hsum} + {10'd0, cur_h} + {10'd0, spacing};
		hsum = (sum > {2'b00, SUM_MAX}) ? SUM_MAX : sum[SUM_W-1:0];
		if (cur_w > widest) begin
			widest = cur_w;
		end
		r.last             = 1'b0;
		r.rec.line_begin   = first_idx;
		r.rec.line_stop    = stop;
		r.rec.line_width   = cur_w;
		r.rec.line_height  = cur_h;
		r.rec.total_width  = widest;
		r.rec.total_height = hsum;
		line_queue.insert(line_queue.size(), r);
	endtask

	task automatic measure_word(input logic cmd, input logic [CODE_W-1:0] code,
			input logic present, input logic [GLYPH_W-1:0] gw, input logic [HGT_W-1:0] gh);
		logic [IDX_W-1:0] i;
		logic [LEN_W:0]   nw;
		logic [SUM_W:0]   th;
		line_rec_t r;
		i = char_idx;
		if (cmd == CMD_END) begin
			th = {1'b0, hsum} + {9'd0, cur_h};
			r.last             = 1'b1;
			r.rec.line_begin   = first_idx;
			r.rec.line_stop    = i;
			r.rec.line_width   = cur_w;
			r.rec.line_height  = cur_h;
			r.rec.total_width  = (cur_w > widest) ? cur_w : widest;
			r.rec.total_height = th[SUM_W] ? SUM_MAX : th[SUM_W-1:0];
			line_queue.insert(line_queue.size(), r);
			clear_string();
		end else begin
			if (code == CH_CR) begin
				close_line(i);
				cur_h     = min_h;
				cur_w     = '0;
				first_idx = step_index(i);
				after_cr  = 1'b1;
			end else if (code == CH_LF) begin
				// an LF right after a CR is part of the same break
				if (!after_cr) begin
					close_line(i);
					cur_h = min_h;
					cur_w = '0;
				end
				after_cr  = 1'b0;
				first_idx = step_index(i);
			end else begin
				after_cr = 1'b0;
				if (present) begin
					nw = {1'b0, cur_w} + {5'd0, gw};
					if (wrap_w != '0 && nw > {1'b0, wrap_w} && cur_w != '0) begin
						close_line(i);
						cur_h     = taller(min_h, gh);
						cur_w     = {4'd0, gw};
						first_idx = i;
					end else begin
						cur_w = nw[LEN_W] ? LEN_MAX : nw[LEN_W-1:0];
						cur_h = taller(cur_h, gh);
					end
				end
			end
			char_idx = step_index(i);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_w  = '0;
			spacing = '0;
			min_h   = MIN_HEIGHT_RST;
			clear_string();
			line_queue.delete();
			error_count     = 0;
			pending         = 0;
			records_checked = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_WRAP_WIDTH: begin
						wrap_w = cfg_data[LEN_W-1:0];
					end
					REG_LINE_SPACING: begin
						spacing = cfg_data[HGT_W-1:0];
					end
					REG_MIN_HEIGHT: begin
						min_h = cfg_data[HGT_W-1:0];
						if (char_idx == '0) begin
							cur_h = min_h;
						end
					end
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready) begin
				measure_word(s_tuser, s_tdata[15:0], s_tdata[16], s_tdata[32:17],
					s_tdata[48:33]);
			end
			if (m_tvalid && m_tready) begin
				got.rec  = m_tdata;
				got.last = m_tlast;
				records_checked++;
				if (line_queue.size() == 0) begin
					error_count++;
					if (error_count <= 10) begin
						$display("%0t: record with nothing expected: begin=%0d stop=%0d last=%0b",
							$time, got.rec.line_begin, got.rec.line_stop, got.last);
					end
				end else begin
					exp_rec = line_queue.pop_front();
					if (got !== exp_rec) begin
						error_count++;
						if (error_count <= 10) begin
							$display("%0t: record %0d mismatch", $time, records_checked);
							$display("  expected begin=%0d stop=%0d w=%0d h=%0d tw=%0d th=%0d last=%0b",
								exp_rec.rec.line_begin, exp_rec.rec.line_stop,
								exp_rec.rec.line_width, exp_rec.rec.line_height,
								exp_rec.rec.total_width, exp_rec.rec.total_height, exp_rec.last);
							$display("  actual   begin=%0d stop=%0d w=%0d h=%0d tw=%0d th=%0d last=%0b",
								got.rec.line_begin, got.rec.line_stop,
								got.rec.line_width, got.rec.line_height,
								got.rec.total_width, got.rec.total_height, got.last);
						end
					end
				end
			end
			pending = line_queue.size();
		end
	end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the text line wrap and measure block.
// ----------------------------------------------------------------------------
// Directed strings hit the field extremes, CR/LF handling, missing and
// overlong glyphs, wrap breaks and width and height saturation; random
// phases then run strings under changing register settings. The scoreboard
// predicts and compares every record.
// ----------------------------------------------------------------------------
module testbench import tlwm_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
	localparam int DRAIN_CYCLES = 4;    // covers the two-stage pipe after the last record

	typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_PATTERN, RX_MOSTLY} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	int error_count;
	int pending;
	int records_checked;
	int words_sent;
	int settings_written;
	int burst_left;
	int hold_asked;
	int hold_served;

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	text_line_wrap_measure_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	tlwm_scoreboard line_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.error_count     (error_count),
		.pending         (pending),
		.records_checked (records_checked)
	);

	// Write one register, then drop the enable before returning so back-to-back
	// writes never touch the enable twice in one step.
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		settings_written++;
	endtask

	// Offer one word and hold it until taken. Words go out in bursts of random
	// length; between bursts valid drops for a random gap (sometimes none).
	task automatic send_word(input logic cmd, input logic [CODE_W-1:0] code,
			input logic present, input logic [GLYPH_W-1:0] gw, input logic [HGT_W-1:0] gh);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {7'b0, gh, gw, present, code};
		do @(posedge clk); while (!s_tready);
		words_sent++;
	endtask

	// Drop valid and wait until every expected record is in and the pipe is quiet.
	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register value leaning toward the ends of its range.
	function automatic int unsigned edge_biased(input int unsigned top, input int unsigned usual);
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return top;
			2:       return $urandom_range(0, top);
			default: return $urandom_range(1, usual);
		endcase
	endfunction

	// Receiver: random stall modes in spans, plus one long hold-off on request.
	initial begin
		rx_mode_t mode;
		int span;
		logic [7:0] pat;
		mode = RX_FREE;
		span = 0;
		pat = 8'b1011_0010;
		hold_served = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				if (span == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					span = $urandom_range(20, 120);
					pat  = 8'($urandom_range(1, 255));
				end
				span--;
				case (mode)
					RX_FREE: begin
						m_tready <= 1'b1;
					end
					RX_COIN: begin
						m_tready <= 1'($urandom_range(0, 1));
					end
					RX_PATTERN: begin
						pat = {pat[6:0], pat[7]};
						m_tready <= pat[0];
					end
					default: begin
						m_tready <= ($urandom_range(0, 9) != 0);
					end
				endcase
			end
		end
	end

	// Guard against a hang.
	initial begin
		#30_000_000;
		$display("Timeout with %0d records still expected", pending);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int budget;
		int len;
		int kind;

		words_sent = 0;
		settings_written = 0;
		burst_left = 0;
		hold_asked = 0;
		arst_n    <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= CMD_CHAR;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: no wrap, no spacing, 256 minimum height.
		send_word(CMD_CHAR, 16'h0041, 1'b1, 16'h0000, 16'h0000);
		send_word(CMD_CHAR, 16'h0042, 1'b1, 16'hFFFF, 16'hFFFF);
		// missing glyph: takes an index, adds nothing
		send_word(CMD_CHAR, 16'hFFFF, 1'b0, 16'h1234, 16'h4321);
		send_word(CMD_CHAR, CH_CR, 1'b1, 16'h0010, 16'h0010);
		// LF right after CR: no record of its own
		send_word(CMD_CHAR, CH_LF, 1'b1, 16'h0010, 16'h0010);
		// lone LF: empty line
		send_word(CMD_CHAR, CH_LF, 1'b0, 16'h0000, 16'h0000);
		send_word(CMD_CHAR, 16'h0000, 1'b1, 16'd100, 16'd50);
		// end word with junk in the ignored fields, then an end on an empty string
		send_word(CMD_END, CH_CR, 1'b1, 16'hFFFF, 16'hFFFF);
		send_word(CMD_END, 16'h0000, 1'b0, 16'h0000, 16'h0000);
		settle();

		// Narrow wrap, zero minimum height (reloads the idle line height).
		put_reg(REG_WRAP_WIDTH, 20'd160);
		put_reg(REG_LINE_SPACING, 20'd16);
		put_reg(REG_MIN_HEIGHT, 20'd0);
		send_word(CMD_CHAR, 16'h0061, 1'b1, 16'd100, 16'd300);
		send_word(CMD_CHAR, 16'h0062, 1'b1, 16'd100, 16'd40);
		send_word(CMD_CHAR, 16'h0063, 1'b1, 16'd400, 16'd20);
		send_word(CMD_CHAR, CH_CR, 1'b0, 16'd0, 16'd0);
		// overlong glyph on an empty line: placed without a break
		send_word(CMD_CHAR, 16'h0064, 1'b1, 16'd400, 16'd10);
		send_word(CMD_CHAR, 16'h0065, 1'b1, 16'd60, 16'd10);
		// exactly reaches the wrap width: no break
		send_word(CMD_CHAR, 16'h0066, 1'b1, 16'd100, 16'd10);
		send_word(CMD_CHAR, 16'h0067, 1'b1, 16'd10, 16'd5);
		settle();
		// mid-string minimum height write applies from the next line
		put_reg(REG_MIN_HEIGHT, 20'd500);
		put_reg(REG_WRAP_WIDTH, LEN_MAX);
		send_word(CMD_CHAR, CH_CR, 1'b1, 16'd0, 16'd0);
		send_word(CMD_CHAR, 16'h0068, 1'b1, 16'd30, 16'd700);
		send_word(CMD_END, 16'h0000, 1'b0, 16'd0, 16'd0);
		settle();

		// Width saturation: seventeen full-width glyphs on one line.
		put_reg(REG_WRAP_WIDTH, 20'd0);
		put_reg(REG_MIN_HEIGHT, 20'd256);
		repeat (17) send_word(CMD_CHAR, 16'h0057, 1'b1, 16'hFFFF, 16'd16);
		send_word(CMD_CHAR, CH_CR, 1'b0, 16'd0, 16'd0);
		send_word(CMD_END, 16'h0000, 1'b0, 16'd0, 16'd0);
		settle();

		// Height saturation: tall empty lines with maximum spacing.
		put_reg(REG_LINE_SPACING, 20'hFFFF);
		put_reg(REG_MIN_HEIGHT, 20'hFFFF);
		repeat (130) send_word(CMD_CHAR, CH_CR, 1'b0, 16'd0, 16'd0);
		send_word(CMD_END, 16'h0000, 1'b0, 16'd0, 16'd0);
		settle();

		// Random phases, each under its own register settings; strings may stay
		// open across a phase boundary so writes also land mid-string.
		for (int phase = 0; phase < 8; phase++) begin
			settle();
			put_reg(REG_WRAP_WIDTH, CFG_DATA_W'(edge_biased(32'(LEN_MAX), 3000)));
			put_reg(REG_LINE_SPACING, CFG_DATA_W'(edge_biased(32'hFFFF, 64)));
			put_reg(REG_MIN_HEIGHT, CFG_DATA_W'(edge_biased(32'hFFFF, 400)));
			if (phase == 3) begin
				// long receiver hold-off while line breaks keep coming
				hold_asked++;
				repeat (40) send_word(CMD_CHAR, CH_CR, 1'($urandom_range(0, 1)),
					GLYPH_W'($urandom), HGT_W'($urandom));
			end
			budget = 62;
			while (budget > 0) begin
				if ($urandom_range(0, 6) == 0) begin
					send_word(1'($urandom_range(0, 1)), CODE_W'($urandom),
						1'($urandom_range(0, 1)), GLYPH_W'($urandom), HGT_W'($urandom));
					budget--;
				end else begin
					len = $urandom_range(0, 24);
					for (int k = 0; k < len; k++) begin
						kind = $urandom_range(0, 99);
						if (kind < 8) begin
							send_word(CMD_CHAR, CH_CR, 1'($urandom_range(0, 1)),
								GLYPH_W'($urandom), HGT_W'($urandom));
						end else if (kind < 14) begin
							send_word(CMD_CHAR, CH_LF, 1'($urandom_range(0, 1)),
								GLYPH_W'($urandom), HGT_W'($urandom));
						end else if (kind < 20) begin
							send_word(CMD_CHAR, CH_CR, 1'b1, 16'd0, 16'd0);
							send_word(CMD_CHAR, CH_LF, 1'b1, 16'd0, 16'd0);
						end else if (kind < 27) begin
							send_word(CMD_CHAR, CODE_W'($urandom_range(32, 16'hFFFF)), 1'b0,
								GLYPH_W'($urandom), HGT_W'($urandom));
						end else begin
							send_word(CMD_CHAR, CODE_W'($urandom_range(32, 16'hFFFF)), 1'b1,
								GLYPH_W'(($urandom_range(0, 9) == 0) ? $urandom :
								($urandom_range(0, 19) == 0) ? 0 : $urandom_range(16, 640)),
								HGT_W'(($urandom_range(0, 9) == 0) ? $urandom :
								$urandom_range(0, 600)));
						end
					end
					send_word(CMD_END, CODE_W'($urandom), 1'($urandom_range(0, 1)),
						GLYPH_W'($urandom), HGT_W'($urandom));
					budget -= len + 1;
				end
			end
		end
		settle();

		$display("Covered %0d words, %0d line records, %0d register writes;", words_sent,
			records_checked, settings_written);
		$display("CR/LF breaks, wraps, overlong glyphs, width and height saturation.");
		if (pending != 0) begin
			$display("%0d expected records never arrived", pending);
		end
		if (error_count == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
